@@ rtl/ordered_list_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Concurrent checks that vanish under synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered list engine check failed");
// next-cycle implication
`define OLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered list engine check failed");
`else
`define OLE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OLE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/ole_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Request modes, status codes and the result record.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int OLE_CAPACITY = 16;

    localparam logic [1:0] MODE_INS  = 2'd0;
    localparam logic [1:0] MODE_DELP = 2'd1;
    localparam logic [1:0] MODE_DELV = 2'd2;
    localparam logic [1:0] MODE_DUMP = 2'd3;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_POS_ERR   = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] entry_value;
        logic [7:0]         entry_index;
        logic [7:0]         list_length;
        logic               last;
    } t_result;

endpackage

@@ rtl/ole_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ole_mem #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IW-1:0]        i_rd_addr,
    output logic signed [31:0]   o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic signed [31:0]   i_wr_data
);

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ole_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ole_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_post,
    input  ole_pkg::t_result    i_res,
    output logic                o_can_post,
    output logic                o_valid,
    input  logic                i_ready,
    output ole_pkg::t_result    o_res
);
    import ole_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_post) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_post) begin
            r_res <= i_res;
        end
    end

    assign o_can_post = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

endmodule

@@ rtl/ole_ctrl.sv @@
`timescale 1ns / 1ps
`include "ordered_list_engine_top_defines.svh"
// ----------------------------------------------------------------------------
// Ordered list sequencer
// Walks the entry memory to shift, search and dump.
// ----------------------------------------------------------------------------
module ole_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_position,
    input  logic signed [31:0]  i_value,
    output logic                o_rd_en,
    output logic [IW-1:0]       o_rd_addr,
    input  logic signed [31:0]  i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output logic signed [31:0]  o_wr_data,
    output logic                o_post,
    output ole_pkg::t_result    o_res,
    input  logic                i_can_post
);
    import ole_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_WR   = 4'd2;
    localparam logic [3:0] S_INS_PUT  = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_SRCH_RD  = 4'd6;
    localparam logic [3:0] S_SRCH_CHK = 4'd7;
    localparam logic [3:0] S_DUMP_RD  = 4'd8;
    localparam logic [3:0] S_DUMP_PUT = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic [IW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic signed [31:0] r_val, n_val;
    t_status            r_status, n_status;

    logic          w_accept;
    logic [7:0]    w_pos_m1;
    logic [8:0]    w_pos9;
    logic [8:0]    w_cnt9;
    logic [CW-1:0] w_cnt_m1;
    logic [IW-1:0] w_last_idx;
    logic          w_at_end;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_pos_m1    = i_position - 8'd1;
    assign w_pos9      = 9'(i_position);
    assign w_cnt9      = 9'(r_cnt);
    assign w_cnt_m1    = r_cnt - 1'b1;
    assign w_last_idx  = w_cnt_m1[IW-1:0];
    assign w_at_end    = (r_ptr == w_last_idx);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_val     = r_val;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_ptr;
        o_wr_data = i_rd_data;
        o_post    = 1'b0;
        o_res     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_INS: begin
                            if (i_position == 8'd0 || w_pos9 > w_cnt9 + 9'd1) begin
                                n_status = ST_POS_ERR;
                                n_state  = S_RESP;
                            end else if (r_cnt == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_val = i_value;
                                n_ptr = r_cnt[IW-1:0];
                                n_k   = w_pos_m1[IW-1:0];
                                n_state = (w_pos9 == w_cnt9 + 9'd1) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        MODE_DELP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (i_position == 8'd0 || w_pos9 > w_cnt9) begin
                                n_status = ST_POS_ERR;
                                n_state  = S_RESP;
                            end else begin
                                n_ptr = w_pos_m1[IW-1:0];
                                if (w_pos9 == w_cnt9) begin
                                    n_cnt    = w_cnt_m1;
                                    n_status = ST_OK;
                                    n_state  = S_RESP;
                                end else begin
                                    n_state = S_DEL_RD;
                                end
                            end
                        end
                        MODE_DELV: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_val   = i_value;
                                n_ptr   = '0;
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_DUMP_RD;
                            end
                        end
                    endcase
                end
            end
            // move entry ptr-1 up to ptr, walking down toward the insert point
            S_INS_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_ptr - 1'b1;
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr;
                n_ptr     = r_ptr - 1'b1;
                n_state   = ((r_ptr - 1'b1) == r_k) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_k;
                o_wr_data = r_val;
                n_cnt     = r_cnt + 1'b1;
                n_status  = ST_OK;
                n_state   = S_RESP;
            end
            // move entry ptr+1 down to ptr, walking up to the tail
            S_DEL_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_ptr + 1'b1;
                n_state   = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr;
                n_ptr     = r_ptr + 1'b1;
                if ((r_ptr + 1'b1) == w_last_idx) begin
                    n_cnt    = w_cnt_m1;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_SRCH_RD: begin
                o_rd_en = 1'b1;
                n_state = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (i_rd_data == r_val) begin
                    if (w_at_end) begin
                        n_cnt    = w_cnt_m1;
                        n_status = ST_OK;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else if (w_at_end) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_DUMP_RD: begin
                o_rd_en = 1'b1;
                n_state = S_DUMP_PUT;
            end
            S_DUMP_PUT: begin
                o_res.status      = ST_OK;
                o_res.entry_value = i_rd_data;
                o_res.entry_index = 8'(r_ptr) + 8'd1;
                o_res.list_length = 8'(r_cnt);
                o_res.last        = w_at_end;
                if (i_can_post) begin
                    o_post = 1'b1;
                    if (w_at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        n_state = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                o_res.status      = r_status;
                o_res.list_length = 8'(r_cnt);
                o_res.last        = 1'b1;
                if (i_can_post) begin
                    o_post  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_k      <= n_k;
        r_val    <= n_val;
        r_status <= n_status;
    end

    `OLE_ASSERT_IMP(a_no_rd_wr_overlap, i_clk, i_rst_n, o_rd_en, !o_wr_en)
    `OLE_ASSERT_IMP(a_post_has_room, i_clk, i_rst_n, o_post, i_can_post)
    `OLE_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    `OLE_ASSERT_NXT(a_cnt_step, i_clk, i_rst_n, 1'b1, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == $past(r_cnt) - 1'b1))
    `OLE_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, o_wr_en, r_cnt <= CW'(CAPACITY))

endmodule

@@ rtl/ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed 32-bit values kept in one entry memory.
// ----------------------------------------------------------------------------
// Each request carries a mode: insert at a 1-based position, delete at a
// position, delete the first entry equal to a value, or dump the list.
// Entries sit packed from position 1 in a synchronous memory with one read
// and one write port; insert and delete move every entry behind the target
// one slot, one memory read and one write per moved entry; delete by value
// first reads each entry in turn until it meets a match. A dump emits one
// result per entry, stalling while the consumer leaves a result waiting.
// Requests that fail (bad position, empty list, no match, full list) leave
// the list alone and return one result. A new request is taken once the
// previous one has posted its last result, even while that result still
// waits in the output register. No clearing pass runs after reset: only
// entries below the count are ever read, and they are always written first.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
    parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_position,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_entry_value,
    output logic [7:0]          o_entry_index,
    output logic [7:0]          o_list_length,
    output logic                o_last
);
    import ole_pkg::*;

    // address and count widths for the entry memory
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic               w_rd_en;
    logic [IW-1:0]      w_rd_addr;
    logic signed [31:0] w_rd_data;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    logic signed [31:0] w_wr_data;
    logic               w_post;
    logic               w_can_post;
    t_result            w_res;
    t_result            w_out_res;

    // sequencer: decodes the request and walks the memory
    ole_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_post      (w_post),
        .o_res       (w_res),
        .i_can_post  (w_can_post)
    );

    // entry storage
    ole_mem #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // hold each result until the consumer takes it
    ole_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_post     (w_post),
        .i_res      (w_res),
        .o_can_post (w_can_post),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (w_out_res)
    );

    assign o_status      = w_out_res.status;
    assign o_entry_value = w_out_res.entry_value;
    assign o_entry_index = w_out_res.entry_index;
    assign o_list_length = w_out_res.list_length;
    assign o_last        = w_out_res.last;

endmodule
